// ===== rtl/core/dbpsk_pkg.sv =====
// Shared types, register codes and sine table arithmetic for the DBPSK modulator.
// No dependencies; every other file of the block imports this package.
package dbpsk_pkg;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int STEP_W      = 32;
    localparam int SPB_W       = 7;
    localparam int AMP_W       = 15;
    localparam int SAMPLE_W    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_BIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE       = 2'd2;

    localparam logic [STEP_W-1:0] PHASE_STEP_RESET      = 32'd779132390;
    localparam logic [SPB_W-1:0]  SAMPLES_PER_BIT_RESET = 7'd44;
    localparam logic [AMP_W-1:0]  AMPLITUDE_RESET       = 15'd30000;

    typedef struct packed {
        logic [STEP_W-1:0] phase_step;
        logic [SPB_W-1:0]  spb;               // already limited to 1..max
        logic [AMP_W-1:0]  amplitude;
    } cfg_t;

    // Odd Taylor coefficients of sin(pi/2 x) in Q30, highest order first.
    function automatic logic signed [63:0] sin_coef(input int k);
        logic signed [63:0] c;
        case (k)
            0:       c = -64'sd3864;
            1:       c = 64'sd172272;
            2:       c = -64'sd5026995;
            3:       c = 64'sd85569306;
            4:       c = -64'sd693598668;
            default: c = 64'sd1686629713;
        endcase
        return c;
    endfunction

    // Sign-magnitude Q30 product, truncated toward zero.
    function automatic logic signed [63:0] mul_q30(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic        neg;
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] r;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? 64'(-a) : 64'(a);
        ub  = (b < 0) ? 64'(-b) : 64'(b);
        r   = (ua * ub) >> 30;
        return neg ? -$signed(r) : $signed(r);
    endfunction

    // Quarter-wave entry q of a table with 2^qbits steps per quadrant, Q15.
    function automatic logic [AMP_W-1:0] quarter_entry(input int q, input int qbits);
        logic signed [63:0] x;
        logic signed [63:0] x2;
        logic signed [63:0] r;
        logic signed [63:0] s;
        x  = 64'(q) <<< (30 - qbits);
        x2 = mul_q30(x, x);
        r  = sin_coef(0);
        for (int k = 1; k < 6; k++)
        begin
            r = sin_coef(k) + mul_q30(r, x2);
        end
        s = mul_q30(r, x);
        if (s < 0)
        begin
            s = 0;
        end
        s = (s + 64'sd16384) >>> 15;
        if (s > 64'sd32767)
        begin
            s = 64'sd32767;
        end
        return s[AMP_W-1:0];
    endfunction

endpackage

// ===== rtl/core/dbpsk_cfg.sv =====
// Configuration registers of the DBPSK modulator, with the samples-per-bit limit.
// Depends on dbpsk_pkg.
module dbpsk_cfg import dbpsk_pkg::*; #(
    parameter int MAX_SAMPLES_PER_BIT = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [STEP_W-1:0] phase_step_reg;
    logic [SPB_W-1:0]  spb_reg;
    logic [AMP_W-1:0]  amplitude_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= PHASE_STEP_RESET;
            spb_reg        <= SAMPLES_PER_BIT_RESET;
            amplitude_reg  <= AMPLITUDE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PHASE_STEP:      phase_step_reg <= cfg_data[STEP_W-1:0];
                CFG_SAMPLES_PER_BIT: spb_reg        <= cfg_data[SPB_W-1:0];
                CFG_AMPLITUDE:       amplitude_reg  <= cfg_data[AMP_W-1:0];
                default:             ;
            endcase
        end
    end

    // Zero acts as one; anything above the limit saturates.
    always_comb
    begin
        cfg.phase_step = phase_step_reg;
        cfg.amplitude  = amplitude_reg;
        if (spb_reg == '0)
        begin
            cfg.spb = SPB_W'(1);
        end
        else if (spb_reg > SPB_W'(MAX_SAMPLES_PER_BIT))
        begin
            cfg.spb = SPB_W'(MAX_SAMPLES_PER_BIT);
        end
        else
        begin
            cfg.spb = spb_reg;
        end
    end

endmodule

// ===== rtl/core/dbpsk_seq.sv =====
// Bit sequencer: takes one data bit, tracks phase inversion and steps the carrier
// phase accumulator once per emitted sample. Depends on dbpsk_pkg.
module dbpsk_seq import dbpsk_pkg::*; #(
    parameter int PHASE_BITS          = 32,
    parameter int SINE_TABLE_BITS     = 10,
    parameter int MAX_SAMPLES_PER_BIT = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  logic                       advance,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       data_bit,
    output logic                       s1_valid,
    output logic [SINE_TABLE_BITS-1:0] s1_idx,
    output logic                       s1_inv,
    output logic                       s1_last
);

    localparam int CNT_W = $clog2(MAX_SAMPLES_PER_BIT + 1);

    logic                       busy_reg, busy_next;
    logic [CNT_W-1:0]           rem_reg, rem_next;
    logic                       inv_reg, inv_next;
    logic [PHASE_BITS-1:0]      phase_reg, phase_next;
    logic                       s1_valid_reg, s1_valid_next;
    logic [SINE_TABLE_BITS-1:0] s1_idx_reg;
    logic                       s1_inv_reg;
    logic                       s1_last_reg;

    logic                       last;
    logic                       issue;
    logic                       accept;
    logic [PHASE_BITS+STEP_W-1:0] step_ext;
    logic [PHASE_BITS-1:0]      step;

    // Step taken modulo 2^PHASE_BITS, zero-extended when the accumulator is wider.
    assign step_ext = {{PHASE_BITS{1'b0}}, cfg.phase_step};
    assign step     = step_ext[PHASE_BITS-1:0];

    assign last     = (rem_reg == '0);
    assign issue    = busy_reg && advance;
    assign in_stall = busy_reg && !(last && advance);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        busy_next     = busy_reg;
        rem_next      = rem_reg;
        inv_next      = inv_reg;
        phase_next    = phase_reg;
        s1_valid_next = s1_valid_reg;
        if (advance)
        begin
            s1_valid_next = issue;
        end
        if (issue)
        begin
            phase_next = phase_reg + step;
            rem_next   = rem_reg - CNT_W'(1);
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
        if (accept)
        begin
            busy_next = 1'b1;
            inv_next  = inv_reg ^ data_bit;
            rem_next  = CNT_W'(cfg.spb) - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            rem_reg      <= '0;
            inv_reg      <= 1'b0;
            phase_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            rem_reg      <= rem_next;
            inv_reg      <= inv_next;
            phase_reg    <= phase_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Capture the current phase, the inversion flag and the last flag for the sample being issued.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_idx_reg  <= phase_reg[PHASE_BITS-1 -: SINE_TABLE_BITS];
            s1_inv_reg  <= inv_reg;
            s1_last_reg <= last;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_idx   = s1_idx_reg;
    assign s1_inv   = s1_inv_reg;
    assign s1_last  = s1_last_reg;

endmodule

// ===== rtl/core/dbpsk_sine.sv =====
// Sine lookup stage: quarter-wave constant table with quadrant folding.
// Depends on dbpsk_pkg for the table arithmetic.
module dbpsk_sine import dbpsk_pkg::*; #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic                       s1_valid,
    input  logic [SINE_TABLE_BITS-1:0] s1_idx,
    input  logic                       s1_inv,
    input  logic                       s1_last,
    output logic                       s2_valid,
    output logic [AMP_W-1:0]           s2_mag,
    output logic                       s2_neg,
    output logic                       s2_last
);

    localparam int QB   = SINE_TABLE_BITS - 2;
    localparam int QLEN = (1 << QB) + 1;

    logic [AMP_W-1:0] quarter_tab [QLEN];

    for (genvar g = 0; g < QLEN; g++)
    begin : g_tab
        assign quarter_tab[g] = quarter_entry(g, QB);
    end

    logic [1:0]    quad;
    logic [QB-1:0] q;
    logic [QB:0]   addr;
    logic          s2_valid_reg;
    logic [AMP_W-1:0] s2_mag_reg;
    logic          s2_neg_reg;
    logic          s2_last_reg;

    assign quad = s1_idx[SINE_TABLE_BITS-1 -: 2];
    assign q    = s1_idx[QB-1:0];
    // Mirror the index in the second and fourth quadrants.
    assign addr = quad[0] ? ({1'b1, {QB{1'b0}}} - {1'b0, q}) : {1'b0, q};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_mag_reg  <= quarter_tab[addr];
            s2_neg_reg  <= quad[1] ^ s1_inv;
            s2_last_reg <= s1_last;
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2_mag   = s2_mag_reg;
    assign s2_neg   = s2_neg_reg;
    assign s2_last  = s2_last_reg;

endmodule

// ===== rtl/core/dbpsk_scale.sv =====
// Output stage: scales the table magnitude by the amplitude, applies the sign
// and holds the sample register. Depends on dbpsk_pkg.
module dbpsk_scale import dbpsk_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic [AMP_W-1:0]           amplitude,
    input  logic                       s2_valid,
    input  logic [AMP_W-1:0]           s2_mag,
    input  logic                       s2_neg,
    input  logic                       s2_last,
    output logic                       out_valid,
    output logic signed [SAMPLE_W-1:0] sample,
    output logic                       last_of_bit
);

    logic [2*AMP_W-1:0]   product;
    logic [SAMPLE_W-1:0]  mag;
    logic [SAMPLE_W-1:0]  signed_val;
    logic                 valid_reg;
    logic [SAMPLE_W-1:0]  sample_reg;
    logic                 last_reg;

    // Truncate toward zero: scale the magnitude, then apply the sign.
    assign product    = amplitude * s2_mag;
    assign mag        = {1'b0, product[2*AMP_W-1 -: AMP_W]};
    assign signed_val = s2_neg ? (~mag + SAMPLE_W'(1)) : mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= s2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sample_reg <= signed_val;
            last_reg   <= s2_last;
        end
    end

    assign out_valid   = valid_reg;
    assign sample      = $signed(sample_reg);
    assign last_of_bit = last_reg;

endmodule

// ===== rtl/core/dbpsk_carrier_modulator_top.sv =====
// DBPSK carrier modulator, one data bit in, a configurable run of carrier samples out.
// Depends on dbpsk_pkg, dbpsk_cfg, dbpsk_seq, dbpsk_sine and dbpsk_scale.
//
// Each accepted data bit produces N samples, N being the samples-per-bit register
// (a written 0 acts as 1, values above MAX_SAMPLES_PER_BIT saturate), one per clock
// while out_stall is low; the sequencer's sample counter tracks that run. The next
// bit is taken in the cycle its predecessor's last sample is issued, so bits stream
// without gaps. An issued sample passes the phase capture, sine lookup and amplitude
// multiply registers in turn before it appears at the output.
// A one toggles the phase inversion before its own samples; the carrier phase
// accumulator runs freely across bits. Write configuration only while idle.
module dbpsk_carrier_modulator_top import dbpsk_pkg::*; #(
    parameter int PHASE_BITS          = 32,
    parameter int SINE_TABLE_BITS     = 10,
    parameter int MAX_SAMPLES_PER_BIT = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       data_bit,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] sample,
    output logic                       last_of_bit
);

    cfg_t                       cfg;
    logic                       advance;
    logic                       s1_valid;
    logic [SINE_TABLE_BITS-1:0] s1_idx;
    logic                       s1_inv;
    logic                       s1_last;
    logic                       s2_valid;
    logic [AMP_W-1:0]           s2_mag;
    logic                       s2_neg;
    logic                       s2_last;

    // Whole pipeline moves unless a finished sample is held by the consumer.
    assign advance = !out_valid || !out_stall;

    dbpsk_cfg #(
        .MAX_SAMPLES_PER_BIT(MAX_SAMPLES_PER_BIT)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    dbpsk_seq #(
        .PHASE_BITS         (PHASE_BITS),
        .SINE_TABLE_BITS    (SINE_TABLE_BITS),
        .MAX_SAMPLES_PER_BIT(MAX_SAMPLES_PER_BIT)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (advance),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_bit(data_bit),
        .s1_valid(s1_valid),
        .s1_idx  (s1_idx),
        .s1_inv  (s1_inv),
        .s1_last (s1_last)
    );

    dbpsk_sine #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_sine (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .s1_valid(s1_valid),
        .s1_idx  (s1_idx),
        .s1_inv  (s1_inv),
        .s1_last (s1_last),
        .s2_valid(s2_valid),
        .s2_mag  (s2_mag),
        .s2_neg  (s2_neg),
        .s2_last (s2_last)
    );

    dbpsk_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .amplitude  (cfg.amplitude),
        .s2_valid   (s2_valid),
        .s2_mag     (s2_mag),
        .s2_neg     (s2_neg),
        .s2_last    (s2_last),
        .out_valid  (out_valid),
        .sample     (sample),
        .last_of_bit(last_of_bit)
    );

    // An issued sample reaches the lookup stage on the next edge when the pipeline advances.
    a_s1_to_s2: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid && advance) |=> s2_valid)
        else $error("issued sample lost before sine lookup");

    // A looked-up sample reaches the output register on the next edge when the pipeline advances.
    a_s2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid && advance) |=> out_valid)
        else $error("looked-up sample lost before output");

    // Scaled magnitude never reaches full scale.
    a_no_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sample != -16'sd32768))
        else $error("sample reached -32768");

    // Hold a stalled output transaction unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(sample)
            && $stable(last_of_bit)))
        else $error("stalled output transaction changed");

endmodule

// ===== test/dbpsk_carrier_modulator_top_tb.sv =====
// Self-checking testbench for dbpsk_carrier_modulator_top: random bit streams, config sweeps.
// Depends on dbpsk_pkg and the modulator RTL; the expected samples come from a model kept here.
`timescale 1ns / 1ps

module dbpsk_carrier_modulator_top_tb;
    import dbpsk_pkg::*;

    localparam int PHASE_BITS      = 32;
    localparam int SINE_TABLE_BITS = 10;
    localparam int MAX_SPB         = 64;
    localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
    localparam int QUARTER_SPAN    = 1 << QUARTER_BITS;
    localparam int QUARTER_LEN     = QUARTER_SPAN + 1;
    localparam int SETTLE_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_PHASES   = 10;
    localparam int PHASE_ITEMS     = 41;
    localparam int REPORT_LIMIT    = 50;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic signed [SAMPLE_W-1:0] value;
        logic                       last_flag;
    } carrier_sample_t;

    typedef struct {
        logic        value;
        int unsigned gap;
    } bit_item_t;

    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       data_bit = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_of_bit;

    // model state and register copies
    logic [PHASE_BITS-1:0] phase_acc;
    logic                  inverted;
    logic [STEP_W-1:0]     step_reg;
    logic [SPB_W-1:0]      spb_reg;
    logic [AMP_W-1:0]      amp_reg;
    int                    quarter_wave [0:QUARTER_LEN-1];

    carrier_sample_t carrier_samples [$];
    bit_item_t       bit_queue [$];
    bit_item_t       next_bit;
    bit              sender_steady = 1'b0;
    bit              receiver_steady = 1'b0;
    int              hold_left = 0;
    int              mismatch_count = 0;
    int              quiet_cycles = 0;

    dbpsk_carrier_modulator_top #(
        .PHASE_BITS          (PHASE_BITS),
        .SINE_TABLE_BITS     (SINE_TABLE_BITS),
        .MAX_SAMPLES_PER_BIT (MAX_SPB)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_bit    (data_bit),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample      (sample),
        .last_of_bit (last_of_bit)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Q30 product in sign-magnitude form, truncated toward zero
    function automatic longint q30_mul(input longint a, input longint b);
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned prod;
        ma   = (a < 0) ? -a : a;
        mb   = (b < 0) ? -b : b;
        prod = (ma * mb) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(prod) : longint'(prod);
    endfunction

    // Expected samples of one data bit; advances the phase and inversion state.
    task automatic modulate_bit(input logic bit_in);
        int unsigned                n;
        int unsigned                i;
        logic [SINE_TABLE_BITS-1:0] idx;
        logic [QUARTER_BITS-1:0]    q;
        int                         mag;
        logic                       neg;
        logic [31:0]                scaled;
        carrier_sample_t            s;
        n = (spb_reg == 0) ? 1 : ((spb_reg > MAX_SPB) ? MAX_SPB : spb_reg);
        if (bit_in)
        begin
            inverted = !inverted;
        end
        for (i = 0; i < n; i++)
        begin
            idx    = phase_acc[PHASE_BITS-1 -: SINE_TABLE_BITS];
            q      = idx[QUARTER_BITS-1:0];
            // odd quadrants run the quarter wave backwards, the upper half is negative
            mag    = idx[QUARTER_BITS] ? quarter_wave[QUARTER_SPAN - int'(q)] : quarter_wave[q];
            neg    = idx[SINE_TABLE_BITS-1] ^ inverted;
            scaled = (32'(amp_reg) * 32'(mag)) >> 15;
            s.value     = neg ? 16'(-scaled) : 16'(scaled);
            s.last_flag = (i == n - 1);
            carrier_samples.push_back(s);
            phase_acc = phase_acc + step_reg[PHASE_BITS-1:0];
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_PHASE_STEP:      step_reg = val[STEP_W-1:0];
            CFG_SAMPLES_PER_BIT: spb_reg  = val[SPB_W-1:0];
            CFG_AMPLITUDE:       amp_reg  = val[AMP_W-1:0];
            default:             ;
        endcase
    endtask

    task automatic queue_bit(input logic value);
        bit_item_t it;
        it.value = value;
        it.gap   = sender_steady ? 0 : $urandom_range(0, 6);
        bit_queue.push_back(it);
    endtask

    task automatic queue_random_bits(input int count);
        for (int k = 0; k < count; k++)
        begin
            queue_bit(1'($urandom_range(0, 1)));
        end
    endtask

    // Block until every bit is taken and every sample is out, then let the pipe settle.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (bit_queue.size() != 0 || in_valid || carrier_samples.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Bit driver: present one transaction at a time, idle the drawn gap first.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            data_bit <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                modulate_bit(data_bit);
            end
            if (!in_valid || !in_stall)
            begin
                if (bit_queue.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (bit_queue[0].gap > 0)
                begin
                    bit_queue[0].gap = bit_queue[0].gap - 1;
                    in_valid <= 1'b0;
                end
                else
                begin
                    next_bit = bit_queue.pop_front();
                    in_valid <= 1'b1;
                    data_bit <= next_bit.value;
                end
            end
        end
    end

    // Sample monitor: check each accepted transaction, then stall for a drawn count.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (carrier_samples.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("%0t: unexpected sample, expected none, actual %0d last %0b",
                                 $time, sample, last_of_bit);
                    end
                end
                else
                begin
                    carrier_sample_t want;
                    want = carrier_samples.pop_front();
                    if (sample !== want.value)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                        begin
                            $display("%0t: sample mismatch, expected %0d, actual %0d",
                                     $time, want.value, sample);
                        end
                    end
                    if (last_of_bit !== want.last_flag)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                        begin
                            $display("%0t: last_of_bit mismatch, expected %0b, actual %0b",
                                     $time, want.last_flag, last_of_bit);
                        end
                    end
                end
                hold_left = receiver_steady ? 0 : $urandom_range(0, 6);
            end
            else if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
            end
            out_stall <= (hold_left != 0);
        end
    end

    // Watchdog on cycles without any accepted transaction or register write
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        longint                arg;
        longint                arg_sq;
        longint                poly;
        logic [CFG_DATA_W-1:0] word;
        logic [STEP_W-1:0]     step_pick;
        logic [SPB_W-1:0]      spb_pick;
        logic [AMP_W-1:0]      amp_pick;

        // quarter-wave sine, Q15, from a Horner chain over the odd Taylor terms in Q30
        for (int qi = 0; qi < QUARTER_LEN; qi++)
        begin
            arg    = longint'(qi) << (30 - QUARTER_BITS);
            arg_sq = q30_mul(arg, arg);
            poly   = -64'sd3864;
            poly   = 64'sd172272 + q30_mul(poly, arg_sq);
            poly   = -64'sd5026995 + q30_mul(poly, arg_sq);
            poly   = 64'sd85569306 + q30_mul(poly, arg_sq);
            poly   = -64'sd693598668 + q30_mul(poly, arg_sq);
            poly   = 64'sd1686629713 + q30_mul(poly, arg_sq);
            poly   = q30_mul(poly, arg);
            if (poly < 0)
            begin
                poly = 0;
            end
            poly = (poly + 64'sd16384) >>> 15;
            if (poly > 64'sd32767)
            begin
                poly = 64'sd32767;
            end
            quarter_wave[qi] = int'(poly);
        end

        phase_acc = '0;
        inverted  = 1'b0;
        step_reg  = PHASE_STEP_RESET;
        spb_reg   = SAMPLES_PER_BIT_RESET;
        amp_reg   = AMPLITUDE_RESET;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset settings first
        queue_bit(1'b1);
        queue_bit(1'b0);
        queue_bit(1'b1);
        queue_bit(1'b1);
        queue_bit(1'b0);

        // zero samples per bit acts as one; full-scale step and amplitude
        wait_idle();
        write_reg(CFG_SAMPLES_PER_BIT, 32'd0);
        write_reg(CFG_PHASE_STEP, 32'hFFFF_FFFF);
        write_reg(CFG_AMPLITUDE, 32'(AMP_W'('1)));
        queue_bit(1'b1);
        queue_bit(1'b1);
        queue_bit(1'b0);
        queue_bit(1'b1);

        // oversized samples per bit saturates; frozen phase, zero amplitude
        wait_idle();
        write_reg(CFG_SAMPLES_PER_BIT, 32'd127);
        write_reg(CFG_PHASE_STEP, 32'd0);
        write_reg(CFG_AMPLITUDE, 32'd0);
        queue_bit(1'b0);
        queue_bit(1'b1);

        // sweep the whole table four entries per sample, across every quadrant edge
        wait_idle();
        write_reg(CFG_SAMPLES_PER_BIT, 32'(MAX_SPB));
        write_reg(CFG_PHASE_STEP, 32'h0100_0000);
        write_reg(CFG_AMPLITUDE, 32'(AMP_W'('1)));
        queue_bit(1'b1);
        queue_bit(1'b0);
        queue_bit(1'b0);
        queue_bit(1'b1);

        // one sample per bit at half-turn steps; the spare index must be ignored
        wait_idle();
        write_reg(CFG_SAMPLES_PER_BIT, 32'd1);
        write_reg(CFG_PHASE_STEP, 32'h8000_0000);
        write_reg(CFG_AMPLITUDE, 32'd12345);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        queue_bit(1'b1);
        queue_bit(1'b1);
        queue_bit(1'b1);
        queue_bit(1'b0);
        queue_bit(1'b0);

        // Random phases, each with fresh settings and idling style
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_idle();
            sender_steady   = (ph % 4 == 1);
            receiver_steady = (ph % 3 == 2);

            step_pick = (ph == 1) ? 32'hFFFF_FFFF : ((ph == 2) ? 32'd0 : 32'($urandom));
            spb_pick  = (ph == 3) ? SPB_W'($urandom_range(MAX_SPB, 127))
                      : ((ph == 6) ? SPB_W'(0) : SPB_W'($urandom_range(1, 8)));
            amp_pick  = (ph == 4) ? AMP_W'(0)
                      : ((ph == 5) ? AMP_W'('1) : AMP_W'($urandom_range(0, 32767)));

            write_reg(CFG_PHASE_STEP, 32'(step_pick));
            // junk above the register width must be dropped
            word = $urandom;
            word[SPB_W-1:0] = spb_pick;
            write_reg(CFG_SAMPLES_PER_BIT, word);
            word = $urandom;
            word[AMP_W-1:0] = amp_pick;
            write_reg(CFG_AMPLITUDE, word);
            if (ph == 0)
            begin
                write_reg(CFG_UNUSED, 32'($urandom));
            end

            if (ph == 4)
            begin
                // hold the sender until the pipe has drained, then resume
                queue_random_bits(PHASE_ITEMS / 2);
                wait_idle();
                queue_random_bits(PHASE_ITEMS - PHASE_ITEMS / 2);
            end
            else
            begin
                queue_random_bits(PHASE_ITEMS);
            end
        end

        wait_idle();
        if (mismatch_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
